// ===== hdl/binary_frame_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Binary frame deframer assertion macros
// Assertion helpers shared by the deframer RTL; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define BINARY_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// The expression must never be true outside reset.
`define BFD_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("deframer assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define BFD_ASSERT_NEVER(lbl, clk, rst, expr)
`define BFD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define BFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary frame deframer package
// Sizes, register indexes, status codes and the command word that passes
// from the parser to the emitter.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // Payload buffer size and the widths that follow from it.
  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int PLEN_W      = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 16;

  // Command queue between parser and emitter.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_END_SECOND   = CFG_IDX_W'(3);

  localparam logic [BYTE_W-1:0] RST_START_FIRST  = 8'hA0;
  localparam logic [BYTE_W-1:0] RST_START_SECOND = 8'hA1;
  localparam logic [BYTE_W-1:0] RST_END_FIRST    = 8'h0D;
  localparam logic [BYTE_W-1:0] RST_END_SECOND   = 8'h0A;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_MORE  = 2'd0,
    STATUS_ERROR = 2'd1,
    STATUS_READY = 2'd2
  } status_t;

  // One command per accepted input beat.
  typedef struct packed {
    status_t             kind;
    logic [PLEN_W-1:0]   plen;
    logic [BYTE_W-1:0]   csum;
    logic [CNT_W-1:0]    good_cnt;
    logic [CNT_W-1:0]    bad_cnt;
  } cmd_t;

endpackage

// ===== hdl/bfd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bfd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Deframer command queue
// Short register queue that decouples the parser from the emitter.
// ----------------------------------------------------------------------------
module bfd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bfd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bfd_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (bfd_pkg::QUEUE_DEPTH > 1) ? $clog2(bfd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bfd_pkg::QUEUE_DEPTH - 1);

  bfd_pkg::cmd_t    entries [bfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(bfd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Storage has no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/bfd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Front end: takes input beats, tracks the frame phase, stores the payload,
// keeps the running XOR and frame counters, and queues one command per beat.
// ----------------------------------------------------------------------------
module bfd_parser (
  input  logic                              clk,
  input  logic                              rst,
  // Input byte channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bfd_pkg::BYTE_W-1:0]        rx_byte,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfd_pkg::BYTE_W-1:0]        cfg_data,
  // Command queue.
  output logic                              push,
  output bfd_pkg::cmd_t                     push_cmd,
  input  logic                              q_full,
  // Payload buffer write port.
  output logic                              ram_we,
  output logic [bfd_pkg::IDX_W-1:0]         ram_waddr,
  output logic [bfd_pkg::BYTE_W-1:0]        ram_wdata,
  // Emitter finished reading the buffer.
  input  logic                              emit_done
);

  typedef enum logic [7:0] {
    PH_SOF0 = 8'b0000_0001,
    PH_SOF1 = 8'b0000_0010,
    PH_LENH = 8'b0000_0100,
    PH_LENL = 8'b0000_1000,
    PH_DATA = 8'b0001_0000,
    PH_CSUM = 8'b0010_0000,
    PH_EOF0 = 8'b0100_0000,
    PH_EOF1 = 8'b1000_0000
  } phase_t;

  phase_t                         phase, phase_next;
  logic [bfd_pkg::BYTE_W-1:0]     start_first, start_second, end_first, end_second;
  logic [bfd_pkg::BYTE_W-1:0]     len_hi;
  logic [bfd_pkg::PLEN_W-1:0]     exp_len, exp_len_next;
  logic [bfd_pkg::PLEN_W-1:0]     fill, fill_next;
  logic [bfd_pkg::BYTE_W-1:0]     run_xor, run_xor_next;
  logic [bfd_pkg::BYTE_W-1:0]     csum;
  logic [bfd_pkg::CNT_W-1:0]      good_cnt, good_cnt_next;
  logic [bfd_pkg::CNT_W-1:0]      bad_cnt, bad_cnt_next;
  logic                           hold;
  logic                           accept;
  logic [bfd_pkg::LEN_W-1:0]      len_full;
  logic                           len_bad;
  logic [bfd_pkg::PLEN_W-1:0]     fill_inc;
  bfd_pkg::status_t               kind;

  // The buffer belongs to the emitter from a good frame until its run ends.
  assign in_ready  = !q_full && !hold;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign len_full = {len_hi, rx_byte};
  assign len_bad  = (len_full == '0) ||
                    (len_full > bfd_pkg::LEN_W'(bfd_pkg::MAX_PAYLOAD));
  assign fill_inc = fill + bfd_pkg::PLEN_W'(1);

  // Phase decode for one input beat.
  always_comb begin
    phase_next    = phase;
    exp_len_next  = exp_len;
    fill_next     = fill;
    run_xor_next  = run_xor;
    good_cnt_next = good_cnt;
    bad_cnt_next  = bad_cnt;
    kind          = bfd_pkg::STATUS_MORE;
    ram_we        = 1'b0;
    unique case (phase)
      PH_SOF0: begin
        if (rx_byte == start_first) begin
          phase_next = PH_SOF1;
        end
      end
      PH_SOF1: begin
        if (rx_byte == start_second) begin
          phase_next = PH_LENH;
        end else if (rx_byte != start_first) begin
          phase_next = PH_SOF0;
        end
      end
      PH_LENH: begin
        phase_next = PH_LENL;
      end
      PH_LENL: begin
        fill_next    = '0;
        run_xor_next = '0;
        exp_len_next = len_full[bfd_pkg::PLEN_W-1:0];
        if (len_bad) begin
          bad_cnt_next = bad_cnt + bfd_pkg::CNT_W'(1);
          kind         = bfd_pkg::STATUS_ERROR;
          phase_next   = PH_SOF0;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        ram_we       = accept;
        run_xor_next = run_xor ^ rx_byte;
        fill_next    = fill_inc;
        if (fill_inc >= exp_len) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        phase_next = PH_EOF0;
      end
      PH_EOF0: begin
        if (rx_byte != end_first) begin
          bad_cnt_next = bad_cnt + bfd_pkg::CNT_W'(1);
          kind         = bfd_pkg::STATUS_ERROR;
          phase_next   = PH_SOF0;
        end else begin
          phase_next = PH_EOF1;
        end
      end
      PH_EOF1: begin
        phase_next = PH_SOF0;
        if (rx_byte != end_second || run_xor != csum) begin
          bad_cnt_next = bad_cnt + bfd_pkg::CNT_W'(1);
          kind         = bfd_pkg::STATUS_ERROR;
        end else begin
          good_cnt_next = good_cnt + bfd_pkg::CNT_W'(1);
          kind          = bfd_pkg::STATUS_READY;
        end
      end
      default: begin
        phase_next = PH_SOF0;
      end
    endcase
  end

  // Payload write and command for the queue.
  assign ram_waddr = fill[bfd_pkg::IDX_W-1:0];
  assign ram_wdata = rx_byte;
  assign push      = accept;
  always_comb begin
    push_cmd          = '0;
    push_cmd.kind     = kind;
    push_cmd.plen     = exp_len;
    push_cmd.csum     = csum;
    push_cmd.good_cnt = good_cnt_next;
    push_cmd.bad_cnt  = bad_cnt_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= bfd_pkg::RST_START_FIRST;
      start_second <= bfd_pkg::RST_START_SECOND;
      end_first    <= bfd_pkg::RST_END_FIRST;
      end_second   <= bfd_pkg::RST_END_SECOND;
    end else if (cfg_valid) begin
      if (cfg_index == bfd_pkg::REG_START_FIRST) begin
        start_first <= cfg_data;
      end
      if (cfg_index == bfd_pkg::REG_START_SECOND) begin
        start_second <= cfg_data;
      end
      if (cfg_index == bfd_pkg::REG_END_FIRST) begin
        end_first <= cfg_data;
      end
      if (cfg_index == bfd_pkg::REG_END_SECOND) begin
        end_second <= cfg_data;
      end
    end
  end

  // Parse state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SOF0;
      len_hi   <= '0;
      exp_len  <= '0;
      fill     <= '0;
      run_xor  <= '0;
      csum     <= '0;
      good_cnt <= '0;
      bad_cnt  <= '0;
      hold     <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        exp_len  <= exp_len_next;
        fill     <= fill_next;
        run_xor  <= run_xor_next;
        good_cnt <= good_cnt_next;
        bad_cnt  <= bad_cnt_next;
        if (phase == PH_LENH) begin
          len_hi <= rx_byte;
        end
        if (phase == PH_CSUM) begin
          csum <= rx_byte;
        end
      end
      if (accept && kind == bfd_pkg::STATUS_READY) begin
        hold <= 1'b1;
      end else if (emit_done) begin
        hold <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bfd_emitter.sv =====
// ----------------------------------------------------------------------------
// Deframer emitter
// Back end: pops commands, gives one result for a status beat and a run of
// results read from the payload buffer for a good frame.
// ----------------------------------------------------------------------------
`include "binary_frame_deframer_core_defines.svh"

module bfd_emitter (
  input  logic                          clk,
  input  logic                          rst,
  // Command queue.
  input  logic                          q_valid,
  input  bfd_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  // Payload buffer read port.
  output logic                          ram_re,
  output logic [bfd_pkg::IDX_W-1:0]     ram_raddr,
  input  logic [bfd_pkg::BYTE_W-1:0]    ram_rdata,
  output logic                          emit_done,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [bfd_pkg::BYTE_W-1:0]    payload_byte,
  output logic [bfd_pkg::IDX_W-1:0]     byte_index,
  output logic [bfd_pkg::PLEN_W-1:0]    payload_length,
  output logic [bfd_pkg::BYTE_W-1:0]    checksum_value,
  output logic                          last,
  output logic [bfd_pkg::CNT_W-1:0]     good_frame_count,
  output logic [bfd_pkg::CNT_W-1:0]     bad_frame_count
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } bstate_t;

  bstate_t                      state;
  bfd_pkg::cmd_t                act;
  logic [bfd_pkg::IDX_W-1:0]    rd_idx;
  logic                         slot_free;
  logic                         is_last;
  logic                         load_single;

  assign slot_free   = !out_valid || out_ready;
  assign is_last     = (({1'b0, rd_idx} + bfd_pkg::PLEN_W'(1)) == act.plen);
  assign load_single = (state == B_IDLE) && q_valid && slot_free &&
                       (q_cmd.kind != bfd_pkg::STATUS_READY);
  assign q_pop       = (state == B_IDLE) && q_valid &&
                       (slot_free || q_cmd.kind == bfd_pkg::STATUS_READY);
  assign ram_re      = (state == B_READ);
  assign ram_raddr   = rd_idx;
  assign emit_done   = (state == B_LOAD) && slot_free && is_last;

  // Run sequencer: one buffer read, then one output load, per payload byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rd_idx <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_valid && q_cmd.kind == bfd_pkg::STATUS_READY) begin
            rd_idx <= '0;
            state  <= B_READ;
          end
        end
        B_READ: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          if (slot_free) begin
            if (is_last) begin
              state <= B_IDLE;
            end else begin
              rd_idx <= rd_idx + bfd_pkg::IDX_W'(1);
              state  <= B_READ;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Active good-frame command.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid && q_cmd.kind == bfd_pkg::STATUS_READY) begin
      act <= q_cmd;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || ((state == B_LOAD) && slot_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_single) begin
      status           <= q_cmd.kind;
      payload_byte     <= '0;
      byte_index       <= '0;
      payload_length   <= '0;
      checksum_value   <= '0;
      last             <= 1'b1;
      good_frame_count <= q_cmd.good_cnt;
      bad_frame_count  <= q_cmd.bad_cnt;
    end else if ((state == B_LOAD) && slot_free) begin
      status           <= bfd_pkg::STATUS_READY;
      payload_byte     <= ram_rdata;
      byte_index       <= rd_idx;
      payload_length   <= act.plen;
      checksum_value   <= act.csum;
      last             <= is_last;
      good_frame_count <= act.good_cnt;
      bad_frame_count  <= act.bad_cnt;
    end
  end

  // Checks on the run sequencer.
  `BFD_ASSERT_NEVER(a_idx_in_run, clk, rst, (state != B_IDLE) && ({1'b0, rd_idx} >= act.plen))
  `BFD_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, q_valid)
  `BFD_ASSERT_NEXT(a_done_idle, clk, rst, emit_done, state == B_IDLE)
  `BFD_ASSERT_NEXT(a_done_last, clk, rst, emit_done, out_valid && last)

endmodule

// ===== hdl/binary_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Binary frame deframer core
// Finds sync-delimited, length-prefixed, XOR-checked frames in a byte stream
// and emits each good frame's payload as a run of result beats.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    rx_byte
//   result    out_valid / out_ready  status ... bad_frame_count
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input beat is taken whenever the command queue has room, except while
// a good frame's run holds the buffer: input stalls from the end of a good
// frame until its last payload byte is loaded, since the parser and run
// share the buffer. A run reads each payload byte, then loads it for output.
// Reset clears control state only; the payload buffer is not cleared.
// Either side may stall; the queue and the output register absorb it.
// ----------------------------------------------------------------------------
module binary_frame_deframer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bfd_pkg::BYTE_W-1:0]        rx_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfd_pkg::BYTE_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [bfd_pkg::BYTE_W-1:0]        payload_byte,
  output logic [bfd_pkg::IDX_W-1:0]         byte_index,
  output logic [bfd_pkg::PLEN_W-1:0]        payload_length,
  output logic [bfd_pkg::BYTE_W-1:0]        checksum_value,
  output logic                              last,
  output logic [bfd_pkg::CNT_W-1:0]         good_frame_count,
  output logic [bfd_pkg::CNT_W-1:0]         bad_frame_count
);

  logic                          push;
  bfd_pkg::cmd_t                 push_cmd;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  bfd_pkg::cmd_t                 q_cmd;
  logic                          ram_we;
  logic [bfd_pkg::IDX_W-1:0]     ram_waddr;
  logic [bfd_pkg::BYTE_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [bfd_pkg::IDX_W-1:0]     ram_raddr;
  logic [bfd_pkg::BYTE_W-1:0]    ram_rdata;
  logic                          emit_done;

  // Front end.
  bfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .emit_done (emit_done)
  );

  // Command queue.
  bfd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Payload buffer.
  bfd_ram #(
    .WIDTH (bfd_pkg::BYTE_W),
    .DEPTH (bfd_pkg::MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back end.
  bfd_emitter u_emitter (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .emit_done        (emit_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .payload_byte     (payload_byte),
    .byte_index       (byte_index),
    .payload_length   (payload_length),
    .checksum_value   (checksum_value),
    .last             (last),
    .good_frame_count (good_frame_count),
    .bad_frame_count  (bad_frame_count)
  );

endmodule
